[sv/plot_pkg.sv]
// plot_pkg: shared types and constants of the price-level to order translator
// no dependencies; compiled first
`default_nettype none

package plot_pkg;

    localparam int LEVELS  = 64;
    localparam int IDX_W   = $clog2(LEVELS);
    localparam int LIVE_W  = 7;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    // request codes on the feed channel
    localparam logic [1:0] REQ_LEVEL_UPDATE = 2'd0;
    localparam logic [1:0] REQ_BOOK_RESET   = 2'd1;
    localparam logic [1:0] REQ_SEQ_NOTE     = 2'd2;

    // message kinds on the output channel
    localparam logic [1:0] MSG_CANCEL = 2'd0;
    localparam logic [1:0] MSG_NEW    = 2'd1;
    localparam logic [1:0] MSG_DROP   = 2'd2;

    typedef enum logic [1:0] {
        OP_UPDATE,
        OP_BOOK_RESET,
        OP_SEQ_NOTE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic        qty_nz;
        logic [63:0] timestamp;
        logic [63:0] seq_num;
    } cmd_t;

endpackage

`default_nettype wire

[sv/plot_if.sv]
// plot_if: request and message channels with valid/ready handshake
// depends on nothing but the port widths below
`default_nettype none

interface plot_feed_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic        side;
    logic [31:0] price_ticks;
    logic [31:0] quantity;
    logic [63:0] timestamp;
    logic [63:0] sequence_req;

    modport source (
        output valid, req_type, side, price_ticks, quantity, timestamp, sequence_req,
        input  ready
    );
    modport sink (
        input  valid, req_type, side, price_ticks, quantity, timestamp, sequence_req,
        output ready
    );
endinterface

interface plot_msg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  msg_kind;
    logic [31:0] order_id;
    logic        side_res;
    logic [31:0] price_ticks_res;
    logic [31:0] quantity_res;
    logic [63:0] timestamp_res;
    logic        last;
    logic [6:0]  live_count;
    logic [31:0] gap_count;

    modport source (
        output valid, msg_kind, order_id, side_res, price_ticks_res, quantity_res,
               timestamp_res, last, live_count, gap_count,
        input  ready
    );
    modport sink (
        input  valid, msg_kind, order_id, side_res, price_ticks_res, quantity_res,
               timestamp_res, last, live_count, gap_count,
        output ready
    );
endinterface

`default_nettype wire

[sv/plot_front.sv]
// plot_front: accepts feed requests, decodes them into commands, one register stage
// depends on plot_pkg and plot_if
`default_nettype none

module plot_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    plot_feed_if.sink          feed,
    output plot_pkg::cmd_t     push_data,
    output logic               push_valid,
    input  wire logic          push_ready
);
    import plot_pkg::*;

    logic stage_valid_reg;
    cmd_t stage_reg;
    logic accept;
    logic known;
    cmd_t decoded;

    assign feed.ready = !stage_valid_reg || push_ready;
    assign accept     = feed.valid && feed.ready;

    always_comb
    begin
        decoded.side      = feed.side;
        decoded.price     = feed.price_ticks;
        decoded.quantity  = feed.quantity;
        decoded.qty_nz    = (feed.quantity != 32'd0);
        decoded.timestamp = feed.timestamp;
        decoded.seq_num   = feed.sequence_req;
        known             = 1'b1;
        case (feed.req_type)
            REQ_LEVEL_UPDATE: decoded.op = OP_UPDATE;
            REQ_BOOK_RESET:   decoded.op = OP_BOOK_RESET;
            REQ_SEQ_NOTE:     decoded.op = OP_SEQ_NOTE;
            default:
            begin
                // unknown request type is taken and dropped here
                decoded.op = OP_SEQ_NOTE;
                known      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= known;
        end
        else if (push_ready)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= decoded;
        end
    end

    assign push_valid = stage_valid_reg;
    assign push_data  = stage_reg;

endmodule

`default_nettype wire

[sv/plot_queue.sv]
// plot_queue: short command queue between the decode front and the table engine
// depends on plot_pkg
`default_nettype none

module plot_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire plot_pkg::cmd_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output plot_pkg::cmd_t     pop_data
);
    import plot_pkg::*;

    cmd_t                store_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[sv/plot_back.sv]
// plot_back: level table, order id memory, sequence gap counter and message register
// depends on plot_pkg and plot_if
`default_nettype none

module plot_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire plot_pkg::cmd_t pop_data,
    plot_msg_if.source         msg
);
    import plot_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CANCEL,
        ST_NEW,
        ST_RFIND,
        ST_REMIT
    } state_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } find_t;

    function automatic find_t find_first(input logic [LEVELS-1:0] vec);
        find_t res;
        res.hit = 1'b0;
        res.idx = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                res.hit = 1'b1;
                res.idx = IDX_W'(i);
            end
        end
        return res;
    endfunction

    state_t              state_reg;
    logic [LEVELS-1:0]   valid_reg;
    logic                key_side_reg  [LEVELS];
    logic [31:0]         key_price_reg [LEVELS];
    logic [31:0]         id_mem        [LEVELS];
    logic [31:0]         rdata_reg;
    cmd_t                cur_reg;
    logic                free_hit_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [31:0]         next_id_reg;
    logic [63:0]         prior_seq_reg;
    logic                seq_seen_reg;
    logic [31:0]         gap_reg;
    logic [LIVE_W-1:0]   live_reg;

    logic                out_valid_reg;
    logic [1:0]          out_kind_reg;
    logic [31:0]         out_id_reg;
    logic                out_side_reg;
    logic [31:0]         out_price_reg;
    logic [31:0]         out_qty_reg;
    logic [63:0]         out_ts_reg;
    logic                out_last_reg;
    logic [LIVE_W-1:0]   out_live_reg;
    logic [31:0]         out_gap_reg;

    logic [LEVELS-1:0]   match_vec;
    find_t               match_f;
    find_t               free_f;
    find_t               live_f;
    logic                can_emit;
    logic                pop;
    logic                pop_upd;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                do_cancel;
    logic                do_new;
    logic [LEVELS-1:0]   slot_mask;
    logic                rest_any;
    logic                gap_hit;

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_side_reg[i] == pop_data.side)
                           && (key_price_reg[i] == pop_data.price);
        end
    end

    // the matched entry is freed by its cancel, so it counts as free
    assign match_f = find_first(match_vec);
    assign free_f  = find_first(~valid_reg | match_vec);
    assign live_f  = find_first(valid_reg);

    assign can_emit  = !out_valid_reg || msg.ready;
    assign pop       = (state_reg == ST_IDLE) && pop_valid;
    assign pop_ready = (state_reg == ST_IDLE);
    assign pop_upd   = pop && (pop_data.op == OP_UPDATE);
    assign rd_en     = pop_upd || ((state_reg == ST_RFIND) && live_f.hit);
    assign rd_addr   = (state_reg == ST_RFIND) ? live_f.idx : match_f.idx;
    assign do_cancel = ((state_reg == ST_CANCEL) || (state_reg == ST_REMIT)) && can_emit;
    assign do_new    = (state_reg == ST_NEW) && can_emit;
    assign slot_mask = LEVELS'(1) << slot_reg;
    assign rest_any  = |(valid_reg & ~slot_mask);
    assign gap_hit   = seq_seen_reg && (pop_data.seq_num != prior_seq_reg + 64'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            next_id_reg   <= 32'd1;
            prior_seq_reg <= '0;
            seq_seen_reg  <= 1'b0;
            gap_reg       <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= MSG_CANCEL;
            out_id_reg    <= '0;
            out_side_reg  <= 1'b0;
            out_price_reg <= '0;
            out_qty_reg   <= '0;
            out_ts_reg    <= '0;
            out_last_reg  <= 1'b0;
            out_live_reg  <= '0;
            out_gap_reg   <= '0;
        end
        else
        begin
            if (do_cancel || do_new)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (msg.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (do_cancel)
            begin
                out_kind_reg  <= MSG_CANCEL;
                out_id_reg    <= rdata_reg;
                out_side_reg  <= 1'b0;
                out_price_reg <= '0;
                out_qty_reg   <= '0;
                out_ts_reg    <= cur_reg.timestamp;
                out_last_reg  <= (state_reg == ST_CANCEL) ? !cur_reg.qty_nz : !rest_any;
                out_live_reg  <= live_reg - 1'b1;
                out_gap_reg   <= gap_reg;
            end
            else if (do_new)
            begin
                out_kind_reg  <= free_hit_reg ? MSG_NEW : MSG_DROP;
                out_id_reg    <= free_hit_reg ? next_id_reg : 32'd0;
                out_side_reg  <= cur_reg.side;
                out_price_reg <= cur_reg.price;
                out_qty_reg   <= cur_reg.quantity;
                out_ts_reg    <= cur_reg.timestamp;
                out_last_reg  <= 1'b1;
                out_live_reg  <= free_hit_reg ? live_reg + 1'b1 : live_reg;
                out_gap_reg   <= gap_reg;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        case (pop_data.op)
                            OP_UPDATE:
                            begin
                                if (match_f.hit)
                                begin
                                    state_reg <= ST_CANCEL;
                                end
                                else if (pop_data.qty_nz)
                                begin
                                    state_reg <= ST_NEW;
                                end
                            end
                            OP_BOOK_RESET:
                            begin
                                state_reg <= ST_RFIND;
                            end
                            OP_SEQ_NOTE:
                            begin
                                if (gap_hit && (gap_reg != '1))
                                begin
                                    gap_reg <= gap_reg + 32'd1;
                                end
                                seq_seen_reg  <= 1'b1;
                                prior_seq_reg <= pop_data.seq_num;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_CANCEL:
                begin
                    if (do_cancel)
                    begin
                        valid_reg[slot_reg] <= 1'b0;
                        live_reg            <= live_reg - 1'b1;
                        state_reg           <= cur_reg.qty_nz ? ST_NEW : ST_IDLE;
                    end
                end
                ST_NEW:
                begin
                    if (do_new)
                    begin
                        if (free_hit_reg)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            live_reg                <= live_reg + 1'b1;
                            next_id_reg             <= next_id_reg + 32'd1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RFIND:
                begin
                    state_reg <= live_f.hit ? ST_REMIT : ST_IDLE;
                end
                ST_REMIT:
                begin
                    if (do_cancel)
                    begin
                        valid_reg[slot_reg] <= 1'b0;
                        live_reg            <= live_reg - 1'b1;
                        state_reg           <= rest_any ? ST_RFIND : ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload: command, slots, keys and order id memory
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_data;
        end
        if (pop_upd)
        begin
            free_hit_reg <= free_f.hit;
            free_idx_reg <= free_f.idx;
        end
        if (rd_en)
        begin
            slot_reg  <= rd_addr;
            rdata_reg <= id_mem[rd_addr];
        end
        if (do_new && free_hit_reg)
        begin
            key_side_reg[free_idx_reg]  <= cur_reg.side;
            key_price_reg[free_idx_reg] <= cur_reg.price;
            id_mem[free_idx_reg]        <= next_id_reg;
        end
    end

    assign msg.valid           = out_valid_reg;
    assign msg.msg_kind        = out_kind_reg;
    assign msg.order_id        = out_id_reg;
    assign msg.side_res        = out_side_reg;
    assign msg.price_ticks_res = out_price_reg;
    assign msg.quantity_res    = out_qty_reg;
    assign msg.timestamp_res   = out_ts_reg;
    assign msg.last            = out_last_reg;
    assign msg.live_count      = out_live_reg;
    assign msg.gap_count       = out_gap_reg;

endmodule

`default_nettype wire

[sv/price_level_to_order_translator_unit.sv]
// Price-level to order translator. Each request on feed is registered and decoded by the
// front, queued (four deep) and carried out by the table engine, which keeps 64 side/price
// keys with per-entry valid bits (no clearing pass after reset) and the order ids in a
// memory with a registered read. A level update that gives one message does the match and
// id read, then emits; one that cancels and places a new order emits the cancel and then the
// new order; one that gives no message does nothing more. A book reset finds and reads each
// live entry in turn before its cancel, since each cancel waits on the id read, and ends when
// the book is empty; a sequence note gives no message, and an unknown request is dropped by
// the front. Messages leave through an output register; a step that emits waits while that
// register holds a message that msg.ready has not taken.
// depends on plot_pkg, plot_if, plot_front, plot_queue and plot_back
`default_nettype none

module price_level_to_order_translator_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    plot_feed_if.sink   feed,
    plot_msg_if.source  msg
);
    import plot_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t queue_cmd;
    logic queue_valid;
    logic queue_ready;

    plot_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed       (feed),
        .push_data  (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready)
    );

    plot_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    plot_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd),
        .msg        (msg)
    );

endmodule

`default_nettype wire
